FILE: rtl/lge_pkg.sv
`default_nettype none
package lge_pkg;

	// Default grid bounds
	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;

	// Register width and reset value of the grid size registers
	localparam int GRID_W = 7;
	localparam logic [GRID_W-1:0] GRID_RESET = 7'd64;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;

	// Operation codes
	localparam int MODE_W = 3;
	localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_TOGGLE  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ADVANCE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

	// Life rule neighbour counts
	localparam logic [3:0] LIFE_STAY  = 4'd2;
	localparam logic [3:0] LIFE_BIRTH = 4'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CELL,
		ST_ADVANCE,
		ST_CLEAR,
		ST_DONE
	} lge_state_t;

	// Control of the window held in the cell row
	typedef struct packed {
		logic shift;
		logic clear;
	} lge_win_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/lge_ram.sv
`default_nettype none
module lge_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

FILE: rtl/lge_cell.sv
`default_nettype none
module lge_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lge_pkg::lge_win_ctrl_t ctrl,
	input  wire logic                  in_bit,
	input  wire logic [2:0]            left_col,
	input  wire logic [2:0]            right_col,
	output logic      [2:0]            col_bits,
	output logic                       next_bit
);

	import lge_pkg::*;

	// bit 2 newest row, bit 1 row under update, bit 0 row above it
	logic [2:0] col_q;
	logic [3:0] count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctrl.clear) begin
			col_q <= '0;
		end else if (ctrl.shift) begin
			col_q <= {in_bit, col_q[2:1]};
		end
	end

	always_comb begin
		count = 4'($countones({left_col, right_col, col_q[2], col_q[0]}));
		if (col_q[1]) begin
			next_bit = (count == LIFE_STAY) || (count == LIFE_BIRTH);
		end else begin
			next_bit = (count == LIFE_BIRTH);
		end
	end

	assign col_bits = col_q;

endmodule
`default_nettype wire

FILE: rtl/life_grid_engine_unit.sv
`default_nettype none
// Write, toggle and read: the row is read on acceptance, then modified and, for write and
// toggle, written back in ST_CELL; a cell outside the grid in use or an unused mode goes
// straight to ST_DONE. No new item is taken until the result is loaded. Advance: the source
// plane is read one row per cycle into the cell row. Clear: one row write per cycle.
// Reset (arst_n low, asynchronous) clears control state; after release a clearing pass
// zeroes plane 0 with s_axis_tready low. Grid size resets to 64 by 64.
module life_grid_engine_unit #(
	parameter int MAX_ROWS = lge_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = lge_pkg::MAX_COLS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Input items
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [15:0]                    s_axis_tdata,  // row[5:0], col[11:6], value[12]
	input  wire logic [lge_pkg::MODE_W-1:0]     s_axis_tuser,  // mode[2:0]
	// Result items
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [7:0]                          m_axis_tdata,  // cell_value[0]
	output logic                                m_axis_tuser,  // ignored[0]
	// Configuration writes
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [lge_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lge_pkg::GRID_W-1:0]     cfg_data
);

	import lge_pkg::*;

	localparam int RAW   = $clog2(MAX_ROWS);          // row address bits
	localparam int DEPTH = 2 * (2 ** RAW);            // two planes, plane bit on top
	localparam int CIW   = $clog2(MAX_COLS);          // column index bits
	localparam int CNTW  = $clog2(MAX_ROWS + 1);      // row counter, holds MAX_ROWS itself
	localparam int RLW   = (CNTW > GRID_W) ? CNTW : GRID_W;
	localparam int CCW   = ($clog2(MAX_COLS + 1) > GRID_W) ? $clog2(MAX_COLS + 1) : GRID_W;

	// ---------------------------------------------------------------
	// Configuration registers; writes land only while idle
	// ---------------------------------------------------------------
	logic [GRID_W-1:0] grid_rows_q;
	logic [GRID_W-1:0] grid_cols_q;
	logic [RLW-1:0]    rows_use;
	logic [CCW-1:0]    cols_use;

	// Control state, declared early for the configuration handshake
	lge_state_t state_q, state_d;

	assign cfg_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= GRID_RESET;
			grid_cols_q <= GRID_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GRID_ROWS: grid_rows_q <= cfg_data;
				CFG_GRID_COLS: grid_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp the grid in use to the physical bounds
	always_comb begin
		rows_use = (RLW'(grid_rows_q) > RLW'(MAX_ROWS)) ? RLW'(MAX_ROWS) : RLW'(grid_rows_q);
		cols_use = (CCW'(grid_cols_q) > CCW'(MAX_COLS)) ? CCW'(MAX_COLS) : CCW'(grid_cols_q);
	end

	// Live columns of the grid in use
	logic [MAX_COLS-1:0] col_mask;
	for (genvar j = 0; j < MAX_COLS; j++) begin : g_mask
		assign col_mask[j] = (CCW'(j) < cols_use);
	end

	// ---------------------------------------------------------------
	// Input fields
	// ---------------------------------------------------------------
	logic [5:0]        in_row;
	logic [5:0]        in_col;
	logic              in_value;
	logic [MODE_W-1:0] in_mode;
	logic              in_range;
	logic              in_cell_op;
	logic              accept;

	assign in_row   = s_axis_tdata[5:0];
	assign in_col   = s_axis_tdata[11:6];
	assign in_value = s_axis_tdata[12];
	assign in_mode  = s_axis_tuser;

	assign in_range   = (RLW'(in_row) < rows_use) && (CCW'(in_col) < cols_use);
	assign in_cell_op = (in_mode == MODE_WRITE) || (in_mode == MODE_TOGGLE) ||
	                    (in_mode == MODE_READ);

	// ---------------------------------------------------------------
	// Control state
	// ---------------------------------------------------------------
	logic            active_q;    // plane holding the current generation
	logic            clr_resp_q;  // clearing pass owes a result (clear item, not reset)
	logic [CNTW-1:0] step_q;      // row counter of the clearing pass and the advance reads
	logic            adv_run_q;   // advance still issuing row reads
	logic            feed_s1;     // RAM data of a source row arrives this cycle
	logic            wr_s2;       // cell row holds a finished row this cycle
	logic            out_valid_q;

	// Item payload
	logic [MODE_W-1:0] mode_q;
	logic [5:0]        row_q;
	logic [5:0]        col_q;
	logic              value_q;

	// Advance pipeline payload
	logic [CNTW-1:0] feed_row_s1;
	logic [RAW-1:0]  wr_row_s2;
	logic            row_ok_s2;

	// Result payload
	logic res_cell_q;
	logic res_ign_q;
	logic out_cell_q;
	logic out_ign_q;

	logic clear_last;
	logic adv_last;
	logic load_out;
	logic res_load;
	logic res_cell_d;
	logic res_ign_d;

	// RAM side
	logic                ram_we;
	logic [RAW:0]        ram_waddr;
	logic [MAX_COLS-1:0] ram_wdata;
	logic [RAW:0]        ram_raddr;
	logic [MAX_COLS-1:0] ram_rdata;

	// Cell op datapath
	logic [CIW-1:0]      col_idx;
	logic [MAX_COLS-1:0] cell_mask;
	logic [MAX_COLS-1:0] cell_row;

	// Advance datapath
	lge_win_ctrl_t       win_ctrl;
	logic [MAX_COLS-1:0] feed_data;
	logic [MAX_COLS-1:0] next_row;
	logic [2:0]          win_col [MAX_COLS];
	logic [CNTW-1:0]     feed_prev;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign clear_last = (state_q == ST_CLEAR) && (step_q == CNTW'(MAX_ROWS - 1));
	assign adv_last   = (state_q == ST_ADVANCE) && wr_s2 && (wr_row_s2 == RAW'(MAX_ROWS - 1));
	assign load_out   = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	// Modify the addressed bit of the row just read
	assign col_idx   = CIW'(col_q);
	assign cell_mask = {{(MAX_COLS-1){1'b0}}, 1'b1} << col_idx;

	always_comb begin
		case (mode_q)
			MODE_WRITE:  cell_row = value_q ? (ram_rdata | cell_mask) : (ram_rdata & ~cell_mask);
			MODE_TOGGLE: cell_row = ram_rdata ^ cell_mask;
			default:     cell_row = ram_rdata;
		endcase
	end

	// Next state and result selection
	always_comb begin
		state_d    = state_q;
		res_load   = 1'b0;
		res_cell_d = 1'b0;
		res_ign_d  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res_load = 1'b1;
					if (in_cell_op) begin
						res_ign_d = !in_range;
						state_d   = in_range ? ST_CELL : ST_DONE;
					end else if (in_mode == MODE_ADVANCE) begin
						state_d = ST_ADVANCE;
					end else if (in_mode == MODE_CLEAR) begin
						state_d = ST_CLEAR;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_CELL: begin
				res_load   = 1'b1;
				res_cell_d = cell_row[col_idx];
				state_d    = ST_DONE;
			end
			ST_ADVANCE: begin
				if (adv_last) begin
					state_d = ST_DONE;
				end
			end
			ST_CLEAR: begin
				if (clear_last) begin
					state_d = clr_resp_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_DONE: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Counters, plane select and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			clr_resp_q  <= 1'b0;
			step_q      <= '0;
			adv_run_q   <= 1'b0;
			feed_s1     <= 1'b0;
			wr_s2       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && (in_mode == MODE_CLEAR)) begin
				step_q     <= '0;
				clr_resp_q <= 1'b1;
			end else if (accept && (in_mode == MODE_ADVANCE)) begin
				step_q    <= '0;
				adv_run_q <= 1'b1;
			end else if (state_q == ST_CLEAR) begin
				step_q <= step_q + CNTW'(1);
			end else if ((state_q == ST_ADVANCE) && adv_run_q) begin
				// one trailing read past the last row feeds the bottom border
				if (step_q == CNTW'(MAX_ROWS)) begin
					adv_run_q <= 1'b0;
				end else begin
					step_q <= step_q + CNTW'(1);
				end
			end

			feed_s1 <= (state_q == ST_ADVANCE) && adv_run_q;
			wr_s2   <= feed_s1 && (feed_row_s1 != '0);

			if (clear_last) begin
				active_q <= 1'b0;
			end else if (adv_last) begin
				active_q <= ~active_q;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	assign feed_prev = feed_row_s1 - CNTW'(1);

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= in_mode;
			row_q   <= in_row;
			col_q   <= in_col;
			value_q <= in_value;
		end
		feed_row_s1 <= step_q;
		wr_row_s2   <= RAW'(feed_prev);
		row_ok_s2   <= (RLW'(feed_prev) < rows_use);
		if (res_load) begin
			res_cell_q <= res_cell_d;
			res_ign_q  <= res_ign_d;
		end
		if (load_out) begin
			out_cell_q <= res_cell_q;
			out_ign_q  <= res_ign_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_cell_q};
	assign m_axis_tuser  = out_ign_q;

	// ---------------------------------------------------------------
	// Plane memory: read the source row, write the modified, new or zeroed row
	// ---------------------------------------------------------------
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {active_q, RAW'(row_q)};
		ram_wdata = cell_row;
		ram_raddr = {active_q, RAW'(in_row)};
		case (state_q)
			ST_CELL: begin
				ram_we = (mode_q == MODE_WRITE) || (mode_q == MODE_TOGGLE);
			end
			ST_ADVANCE: begin
				ram_raddr = {active_q, step_q[RAW-1:0]};
				ram_we    = wr_s2;
				ram_waddr = {~active_q, wr_row_s2};
				ram_wdata = row_ok_s2 ? (next_row & col_mask) : '0;
			end
			ST_CLEAR: begin
				// plane 1 is fully rewritten by the next advance before it is read
				ram_we    = 1'b1;
				ram_waddr = {1'b0, step_q[RAW-1:0]};
				ram_wdata = '0;
			end
			default: ;
		endcase
	end

	lge_ram #(
		.WIDTH(MAX_COLS),
		.DEPTH(DEPTH)
	) u_planes (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ---------------------------------------------------------------
	// Cell row: one cell per column holds a three-row window and shares
	// its column with its neighbours every cycle
	// ---------------------------------------------------------------
	assign win_ctrl.shift = feed_s1;
	assign win_ctrl.clear = accept && (in_mode == MODE_ADVANCE);

	// Drop rows and columns outside the grid in use so they count as dead
	assign feed_data = (RLW'(feed_row_s1) < rows_use) ? (ram_rdata & col_mask) : '0;

	for (genvar j = 0; j < MAX_COLS; j++) begin : g_cells
		logic [2:0] left_nb;
		logic [2:0] right_nb;

		if (j == 0) begin : g_left_edge
			assign left_nb = 3'b000;
		end else begin : g_left
			assign left_nb = win_col[j-1];
		end

		if (j == MAX_COLS - 1) begin : g_right_edge
			assign right_nb = 3'b000;
		end else begin : g_right
			assign right_nb = win_col[j+1];
		end

		lge_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (win_ctrl),
			.in_bit   (feed_data[j]),
			.left_col (left_nb),
			.right_col(right_nb),
			.col_bits (win_col[j]),
			.next_bit (next_row[j])
		);
	end

endmodule
`default_nettype wire
